// File: src/lrusc_pkg.sv
`default_nettype none

package lrusc_pkg;

  localparam int STATUS_BITS   = 3;
  localparam int SLOT_OUT_BITS = 6;
  localparam int CFG_BITS      = 7;
  localparam int STAMP_BITS    = 64;
  localparam int COUNT_BITS    = 32;

  localparam logic [CFG_BITS-1:0] CFG_RESET = 7'd64;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_HIT       = 3'd0,
    STATUS_FILLED    = 3'd1,
    STATUS_MISSING   = 3'd2,
    STATUS_LOAD_FAIL = 3'd3,
    STATUS_CLEARED   = 3'd4
  } status_t;

  // Saturating increment of a statistics counter.
  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS-1:0] r;
    r = (v == {COUNT_BITS{1'b1}}) ? v : v + COUNT_BITS'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/lru_slot_cache_controller_unit.sv
`default_nettype none

// Fully associative LRU slot directory keyed by a (layer, expert) pair.
//
// Command channel: a transaction is taken at a clock edge with start high and
// busy low. command = 0 runs a lookup, command = 1 zeroes the hit, miss and
// eviction counters. Each transaction yields exactly one result, shown for one
// cycle with done high; the receiver cannot stall, so capture it on that edge.
// The counter outputs always show the current counters.
//
// Lookup: the block reads the directory RAM one entry per cycle through its
// single read port, covering the n enabled slots (slots_in_use clamped to
// 1..SLOT_COUNT). It checks each entry as it comes back, sees the scan drained,
// then writes the hit or victim entry back while the result registers. A new
// start is taken in the cycle that done is high. A clear command answers in the
// cycle after it is accepted.
//
// Reset: after rst drops the block sweeps the directory RAM once to mark every
// slot empty, with busy high. The slots_in_use register is written on its own
// valid/ready channel (always ready). Write it only while idle; not enforced.

module lru_slot_cache_controller_unit #(
  parameter int SLOT_COUNT  = 64,
  parameter int LAYER_BITS  = 6,
  parameter int EXPERT_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // command channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 command,
  input  logic [LAYER_BITS-1:0]                layer_id,
  input  logic [EXPERT_BITS-1:0]               expert_id,
  input  logic                                 content_found,
  input  logic                                 load_ok,
  // result channel
  output logic                                 done,
  output lrusc_pkg::status_t                   status,
  output logic [lrusc_pkg::SLOT_OUT_BITS-1:0]  slot_index,
  output logic                                 evicted_valid,
  output logic [LAYER_BITS-1:0]                evicted_layer,
  output logic [EXPERT_BITS-1:0]               evicted_expert,
  output logic [lrusc_pkg::COUNT_BITS-1:0]     hit_total,
  output logic [lrusc_pkg::COUNT_BITS-1:0]     miss_total,
  output logic [lrusc_pkg::COUNT_BITS-1:0]     eviction_total,
  // configuration channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lrusc_pkg::CFG_BITS-1:0]       cfg_data
);

  import lrusc_pkg::*;

  localparam int SLOT_BITS = $clog2(SLOT_COUNT);
  localparam int CNT_BITS  = $clog2(SLOT_COUNT + 1);

  typedef struct packed {
    logic                   valid;
    logic [LAYER_BITS-1:0]  layer;
    logic [EXPERT_BITS-1:0] expert;
    logic [STAMP_BITS-1:0]  stamp;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t state;

  // Configuration and statistics.
  logic [CFG_BITS-1:0]   slots_in_use;
  logic [STAMP_BITS-1:0] request_clock;
  logic [COUNT_BITS-1:0] hit_counter;
  logic [COUNT_BITS-1:0] miss_counter;
  logic [COUNT_BITS-1:0] evict_counter;

  // Captured request.
  logic [LAYER_BITS-1:0]  req_layer;
  logic [EXPERT_BITS-1:0] req_expert;
  logic                   req_found;
  logic                   req_load_ok;

  // Scan bookkeeping.
  logic [CNT_BITS-1:0]  issue_cnt;
  logic [CNT_BITS-1:0]  scan_limit;
  logic                 chk_valid;
  logic [SLOT_BITS-1:0] chk_idx;
  logic                 hit_found;
  logic [SLOT_BITS-1:0] hit_idx;
  logic                 empty_found;
  logic                 have_old;
  logic [SLOT_BITS-1:0] vic_idx;
  entry_t               vic_entry;

  // RAM interface.
  logic                  ram_we;
  logic [SLOT_BITS-1:0]  ram_waddr;
  logic [ENTRY_BITS-1:0] ram_wdata;
  logic                  ram_re;
  logic [SLOT_BITS-1:0]  ram_raddr;
  logic [ENTRY_BITS-1:0] ram_rdata;

  entry_t rd_entry;
  entry_t wr_entry;
  logic   issuing;
  logic   key_match;
  logic   older;
  logic   accept;
  logic [31:0] cfg_ext;
  logic [31:0] lim_ext;

  lrusc_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (SLOT_COUNT)
  ) u_dir_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy           = (state != ST_IDLE);
  assign accept         = start && !busy;
  assign cfg_ready      = 1'b1;
  assign hit_total      = hit_counter;
  assign miss_total     = miss_counter;
  assign eviction_total = evict_counter;

  // Clamp the enabled slot count to 1..SLOT_COUNT.
  always_comb begin
    cfg_ext = 32'(slots_in_use);
    if (cfg_ext == 32'd0) begin
      lim_ext = 32'd1;
    end else if (cfg_ext > 32'(SLOT_COUNT)) begin
      lim_ext = 32'(SLOT_COUNT);
    end else begin
      lim_ext = cfg_ext;
    end
  end

  always_comb begin
    rd_entry  = entry_t'(ram_rdata);
    issuing   = (state == ST_SCAN) && (issue_cnt != scan_limit);
    ram_re    = issuing;
    ram_raddr = issue_cnt[SLOT_BITS-1:0];
    key_match = rd_entry.valid && (rd_entry.layer == req_layer) &&
                (rd_entry.expert == req_expert);
    // Strictly older keeps the lowest index on ties.
    older     = !have_old || (rd_entry.stamp < vic_entry.stamp);

    ram_we    = 1'b0;
    ram_waddr = issue_cnt[SLOT_BITS-1:0];
    wr_entry  = '0;
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_FINISH: begin
        if (hit_found) begin
          ram_we          = 1'b1;
          ram_waddr       = hit_idx;
          wr_entry.valid  = 1'b1;
          wr_entry.layer  = req_layer;
          wr_entry.expert = req_expert;
          wr_entry.stamp  = request_clock;
        end else if (req_found) begin
          ram_we    = 1'b1;
          ram_waddr = vic_idx;
          if (req_load_ok) begin
            wr_entry.valid  = 1'b1;
            wr_entry.layer  = req_layer;
            wr_entry.expert = req_expert;
            wr_entry.stamp  = request_clock;
          end else begin
            // Failed fill: drop the slot, keep its stamp.
            wr_entry       = vic_entry;
            wr_entry.valid = 1'b0;
          end
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
    ram_wdata = wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      done          <= 1'b0;
      slots_in_use  <= CFG_RESET;
      request_clock <= '0;
      hit_counter   <= '0;
      miss_counter  <= '0;
      evict_counter <= '0;
      issue_cnt     <= '0;
      chk_valid     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        slots_in_use <= cfg_data;
      end

      case (state)
        ST_CLEAR: begin
          // Sweep the directory once, one entry per cycle.
          issue_cnt <= issue_cnt + CNT_BITS'(1);
          if (issue_cnt == CNT_BITS'(SLOT_COUNT - 1)) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (accept) begin
            if (command) begin
              hit_counter    <= '0;
              miss_counter   <= '0;
              evict_counter  <= '0;
              done           <= 1'b1;
              status         <= STATUS_CLEARED;
              slot_index     <= '0;
              evicted_valid  <= 1'b0;
              evicted_layer  <= '0;
              evicted_expert <= '0;
            end else begin
              req_layer     <= layer_id;
              req_expert    <= expert_id;
              req_found     <= content_found;
              req_load_ok   <= load_ok;
              request_clock <= request_clock + STAMP_BITS'(1);
              scan_limit    <= CNT_BITS'(lim_ext);
              issue_cnt     <= '0;
              chk_valid     <= 1'b0;
              hit_found     <= 1'b0;
              empty_found   <= 1'b0;
              have_old      <= 1'b0;
              state         <= ST_SCAN;
            end
          end
        end

        ST_SCAN: begin
          // Issue one read per cycle; check the entry that returns.
          if (issuing) begin
            issue_cnt <= issue_cnt + CNT_BITS'(1);
          end
          chk_valid <= issuing;
          chk_idx   <= issue_cnt[SLOT_BITS-1:0];
          if (chk_valid) begin
            if (key_match && !hit_found) begin
              hit_found <= 1'b1;
              hit_idx   <= chk_idx;
            end
            if (!empty_found) begin
              if (!rd_entry.valid) begin
                empty_found <= 1'b1;
                vic_idx     <= chk_idx;
                vic_entry   <= rd_entry;
              end else if (older) begin
                have_old  <= 1'b1;
                vic_idx   <= chk_idx;
                vic_entry <= rd_entry;
              end
            end
          end
          if (!issuing && !chk_valid) begin
            state <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          done  <= 1'b1;
          state <= ST_IDLE;
          if (hit_found) begin
            status         <= STATUS_HIT;
            slot_index     <= SLOT_OUT_BITS'(hit_idx);
            evicted_valid  <= 1'b0;
            evicted_layer  <= '0;
            evicted_expert <= '0;
            hit_counter    <= sat_inc(hit_counter);
          end else if (!req_found) begin
            status         <= STATUS_MISSING;
            slot_index     <= '0;
            evicted_valid  <= 1'b0;
            evicted_layer  <= '0;
            evicted_expert <= '0;
          end else begin
            slot_index    <= SLOT_OUT_BITS'(vic_idx);
            evicted_valid <= !empty_found;
            if (empty_found) begin
              evicted_layer  <= '0;
              evicted_expert <= '0;
            end else begin
              evicted_layer  <= vic_entry.layer;
              evicted_expert <= vic_entry.expert;
              evict_counter  <= sat_inc(evict_counter);
            end
            if (req_load_ok) begin
              status       <= STATUS_FILLED;
              miss_counter <= sat_inc(miss_counter);
            end else begin
              status <= STATUS_LOAD_FAIL;
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A result only follows a finished lookup or an accepted clear.
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_FINISH) || $past(accept && command))
    else $error("result strobe without a finished transaction");

  // The directory is read-only while the scan is running.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !ram_we)
    else $error("directory write during scan");

  // Write-back stays inside the enabled slot range.
  a_wb_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && ram_we) |-> (CNT_BITS'(ram_waddr) < scan_limit))
    else $error("write-back outside enabled slots");

  // Hit count only drops on a clear.
  a_hit_monotonic: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && hit_counter < $past(hit_counter)) |-> $past(accept && command))
    else $error("hit counter dropped without clear");

endmodule

`default_nettype wire

// File: src/lrusc_ram.sv
`default_nettype none

module lrusc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
